### rtl/core/iss_pkg.sv
package iss_pkg;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	typedef enum logic [1:0] {
		OP_TARGET = 2'd0,
		OP_USB    = 2'd1,
		OP_DRIVE  = 2'd2,
		OP_TICK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		MODE_DISABLED = 2'd0,
		MODE_ENABLED  = 2'd1,
		MODE_ACTIVE   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_ENABLE_BELOW   = 3'd0,
		REG_DISABLE_ABOVE  = 3'd1,
		REG_USB_LOW_LIMIT  = 3'd2,
		REG_USB_HIGH_LIMIT = 3'd3,
		REG_FIVE_VOLT_MIN  = 3'd4,
		REG_THREE_VOLT_MIN = 3'd5,
		REG_THREE_VOLT_MAX = 3'd6,
		REG_CHECK_PERIOD   = 3'd7
	} cfg_idx_t;

	localparam logic [SAMPLE_W-1:0] REQ_LOW_RAIL = 12'd1;
	localparam logic [SAMPLE_W-1:0] REQ_HIGH_RAIL = 12'd2;

	localparam logic signed [SAMPLE_W-1:0] RST_ENABLE_BELOW = 12'sd111;
	localparam logic signed [SAMPLE_W-1:0] RST_DISABLE_ABOVE = 12'sd185;
	localparam logic signed [SAMPLE_W-1:0] RST_USB_LOW_LIMIT = 12'sd1332;
	localparam logic signed [SAMPLE_W-1:0] RST_USB_HIGH_LIMIT = 12'sd1480;
	localparam logic signed [SAMPLE_W-1:0] RST_FIVE_VOLT_MIN = 12'sd1630;
	localparam logic signed [SAMPLE_W-1:0] RST_THREE_VOLT_MIN = 12'sd1110;
	localparam logic signed [SAMPLE_W-1:0] RST_THREE_VOLT_MAX = 12'sd1332;
	localparam logic [PERIOD_W-1:0] RST_CHECK_PERIOD = 16'd25000;

endpackage

### rtl/core/io_supply_supervisor_top.sv
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | opcode, value
// out     | out_valid | out_stall | drive_low_rail, drive_high_rail, switched_power_pin,
//         |           |           | drive_mode, list_changed, state_changed
// cfg     | cfg_we    | none      | cfg_index, cfg_data
//
// one beat per cycle sustained while in_stall is low; a beat passes through the input
// register, then the state update into the result register
// the input register lets a new beat in while a finished result waits under out_stall
// in_stall rises only when both the input register and the result register are full
// arst_n resets the valid flags and supervisor state and loads the register defaults
module io_supply_supervisor_top (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            opcode,
	input  logic signed [iss_pkg::SAMPLE_W-1:0]   value,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic                                  drive_low_rail,
	output logic                                  drive_high_rail,
	output logic                                  switched_power_pin,
	output logic [1:0]                            drive_mode,
	output logic                                  list_changed,
	output logic                                  state_changed,
	input  logic                                  cfg_we,
	input  logic [iss_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [iss_pkg::CFG_DATA_W-1:0]        cfg_data
);
	import iss_pkg::*;

	logic signed [SAMPLE_W-1:0] enable_below_q;
	logic signed [SAMPLE_W-1:0] disable_above_q;
	logic signed [SAMPLE_W-1:0] usb_low_q;
	logic signed [SAMPLE_W-1:0] usb_high_q;
	logic signed [SAMPLE_W-1:0] five_min_q;
	logic signed [SAMPLE_W-1:0] three_min_q;
	logic signed [SAMPLE_W-1:0] three_max_q;
	logic [PERIOD_W-1:0]        period_q;

	logic signed [SAMPLE_W-1:0] target_q;
	mode_t                      mode_q;
	logic                       low_q;
	logic                       high_q;
	logic                       power_q;
	logic [PERIOD_W-1:0]        count_q;
	logic                       armed_q;

	logic                       valid_s1;
	logic [1:0]                 op_s1;
	logic signed [SAMPLE_W-1:0] value_s1;

	logic                       valid_s2;
	logic                       low_s2;
	logic                       high_s2;
	logic                       power_s2;
	mode_t                      mode_s2;
	logic                       list_s2;
	logic                       state_s2;

	logic                       out_free;
	logic                       advance;

	logic signed [SAMPLE_W-1:0] target_n;
	mode_t                      mode_n;
	logic                       low_n;
	logic                       high_n;
	logic                       power_n;
	logic [PERIOD_W-1:0]        count_n;
	logic                       armed_n;
	logic                       list_n;
	logic                       state_n;
	logic                       fail;

	assign out_free = !valid_s2 || !out_stall;
	assign advance = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_below_q <= RST_ENABLE_BELOW;
			disable_above_q <= RST_DISABLE_ABOVE;
			usb_low_q <= RST_USB_LOW_LIMIT;
			usb_high_q <= RST_USB_HIGH_LIMIT;
			five_min_q <= RST_FIVE_VOLT_MIN;
			three_min_q <= RST_THREE_VOLT_MIN;
			three_max_q <= RST_THREE_VOLT_MAX;
			period_q <= RST_CHECK_PERIOD;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				REG_ENABLE_BELOW:   enable_below_q <= cfg_data[SAMPLE_W-1:0];
				REG_DISABLE_ABOVE:  disable_above_q <= cfg_data[SAMPLE_W-1:0];
				REG_USB_LOW_LIMIT:  usb_low_q <= cfg_data[SAMPLE_W-1:0];
				REG_USB_HIGH_LIMIT: usb_high_q <= cfg_data[SAMPLE_W-1:0];
				REG_FIVE_VOLT_MIN:  five_min_q <= cfg_data[SAMPLE_W-1:0];
				REG_THREE_VOLT_MIN: three_min_q <= cfg_data[SAMPLE_W-1:0];
				REG_THREE_VOLT_MAX: three_max_q <= cfg_data[SAMPLE_W-1:0];
				REG_CHECK_PERIOD:   period_q <= cfg_data[PERIOD_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			op_s1 <= opcode;
			value_s1 <= value;
		end
	end

	always_comb begin
		target_n = target_q;
		mode_n = mode_q;
		low_n = low_q;
		high_n = high_q;
		power_n = power_q;
		count_n = count_q;
		armed_n = armed_q;
		list_n = 1'b0;
		state_n = 1'b0;
		fail = 1'b0;

		unique case (op_t'(op_s1))
			OP_TARGET: target_n = value_s1;
			OP_USB: begin
				if (value_s1 < usb_low_q)
					power_n = 1'b1;
				if (value_s1 > usb_high_q)
					power_n = 1'b0;
			end
			OP_DRIVE: begin
				low_n = 1'b0;
				high_n = 1'b0;
				state_n = 1'b1;
				if ((value_s1 == REQ_LOW_RAIL || value_s1 == REQ_HIGH_RAIL)
						&& mode_q != MODE_DISABLED) begin
					count_n = '0;
					armed_n = 1'b1;
					mode_n = MODE_ACTIVE;
					low_n = (value_s1 == REQ_LOW_RAIL);
					high_n = (value_s1 == REQ_HIGH_RAIL);
				end else begin
					armed_n = 1'b0;
					mode_n = MODE_ENABLED;
				end
			end
			OP_TICK: begin
				if (armed_q && count_q < period_q)
					count_n = count_q + 1'b1;
			end
			default: ;
		endcase

		// output window check
		if (mode_n == MODE_ACTIVE && armed_n && count_n >= period_q) begin
			fail = (high_n && target_n < five_min_q)
				|| (!high_n && low_n && (target_n < three_min_q || target_n > three_max_q));
			if (fail) begin
				low_n = 1'b0;
				high_n = 1'b0;
				armed_n = 1'b0;
				mode_n = MODE_ENABLED;
				state_n = 1'b1;
			end
		end

		if (mode_n == MODE_DISABLED && target_n < enable_below_q && !power_n) begin
			mode_n = MODE_ENABLED;
			list_n = 1'b1;
		end
		if ((mode_n == MODE_ENABLED && target_n > disable_above_q)
				|| (mode_n != MODE_DISABLED && power_n)) begin
			low_n = 1'b0;
			high_n = 1'b0;
			mode_n = MODE_DISABLED;
			list_n = 1'b1;
		end
	end

	// supervisor state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			mode_q <= MODE_ENABLED;
			low_q <= 1'b0;
			high_q <= 1'b0;
			power_q <= 1'b1;
			count_q <= '0;
			armed_q <= 1'b0;
		end else if (advance) begin
			target_q <= target_n;
			mode_q <= mode_n;
			low_q <= low_n;
			high_q <= high_n;
			power_q <= power_n;
			count_q <= count_n;
			armed_q <= armed_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			low_s2 <= low_n;
			high_s2 <= high_n;
			power_s2 <= power_n;
			mode_s2 <= mode_n;
			list_s2 <= list_n;
			state_s2 <= state_n;
		end
	end

	assign out_valid = valid_s2;
	assign drive_low_rail = low_s2;
	assign drive_high_rail = high_s2;
	assign switched_power_pin = power_s2;
	assign drive_mode = mode_s2;
	assign list_changed = list_s2;
	assign state_changed = state_s2;

endmodule

### rtl/core/iss_checker.sv
module iss_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic       drive_low_rail,
	input logic       drive_high_rail,
	input logic       switched_power_pin,
	input logic [1:0] drive_mode,
	input logic       list_changed,
	input logic       state_changed
);
	import iss_pkg::*;

	// an output is driven exactly while actively driving
	a_active_drive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((drive_mode == MODE_ACTIVE) == (drive_low_rail || drive_high_rail)))
		else $error("drive outputs disagree with drive mode");

	a_one_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(drive_low_rail && drive_high_rail))
		else $error("both rails driven");

	// switched power forces drive use off
	a_power_disables: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && switched_power_pin) |-> (drive_mode == MODE_DISABLED))
		else $error("drive use left on with switched power");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(drive_low_rail)
			&& $stable(drive_high_rail) && $stable(switched_power_pin)
			&& $stable(drive_mode) && $stable(list_changed) && $stable(state_changed)))
		else $error("stalled beat changed");

endmodule

bind io_supply_supervisor_top iss_checker u_iss_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.drive_low_rail     (drive_low_rail),
	.drive_high_rail    (drive_high_rail),
	.switched_power_pin (switched_power_pin),
	.drive_mode         (drive_mode),
	.list_changed       (list_changed),
	.state_changed      (state_changed)
);

### sim/io_supply_supervisor_top_tb.sv
module io_supply_supervisor_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import iss_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int SHOW_LIMIT = 10;
	localparam logic [SAMPLE_W-1:0] REQ_OFF = '0;
	localparam logic [SAMPLE_W-1:0] REQ_UNUSED = 12'd3;

	typedef struct packed {
		logic low_rail;
		logic high_rail;
		logic power_pin;
		logic [1:0] mode;
		logic list_chg;
		logic state_chg;
	} pin_state_t;

	class supervisor_scoreboard;
		logic signed [SAMPLE_W-1:0] enable_below, disable_above;
		logic signed [SAMPLE_W-1:0] usb_low_limit, usb_high_limit;
		logic signed [SAMPLE_W-1:0] five_volt_min, three_volt_min, three_volt_max;
		logic [PERIOD_W-1:0] check_period;
		logic signed [SAMPLE_W-1:0] target_level;
		mode_t mode;
		logic low_rail_on, high_rail_on, power_pin, check_armed;
		logic [PERIOD_W-1:0] check_count;
		pin_state_t pin_states_q[$];
		int mismatches;

		function new();
			enable_below = RST_ENABLE_BELOW;
			disable_above = RST_DISABLE_ABOVE;
			usb_low_limit = RST_USB_LOW_LIMIT;
			usb_high_limit = RST_USB_HIGH_LIMIT;
			five_volt_min = RST_FIVE_VOLT_MIN;
			three_volt_min = RST_THREE_VOLT_MIN;
			three_volt_max = RST_THREE_VOLT_MAX;
			check_period = RST_CHECK_PERIOD;
			target_level = '0;
			mode = MODE_ENABLED;
			low_rail_on = 1'b0;
			high_rail_on = 1'b0;
			power_pin = 1'b1;
			check_armed = 1'b0;
			check_count = '0;
			mismatches = 0;
		endfunction

		function void write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
			REG_ENABLE_BELOW: enable_below = data[SAMPLE_W-1:0];
			REG_DISABLE_ABOVE: disable_above = data[SAMPLE_W-1:0];
			REG_USB_LOW_LIMIT: usb_low_limit = data[SAMPLE_W-1:0];
			REG_USB_HIGH_LIMIT: usb_high_limit = data[SAMPLE_W-1:0];
			REG_FIVE_VOLT_MIN: five_volt_min = data[SAMPLE_W-1:0];
			REG_THREE_VOLT_MIN: three_volt_min = data[SAMPLE_W-1:0];
			REG_THREE_VOLT_MAX: three_volt_max = data[SAMPLE_W-1:0];
			default: check_period = data[PERIOD_W-1:0];
			endcase
		endfunction

		function void request_drive(logic [SAMPLE_W-1:0] req);
			low_rail_on = 1'b0;
			high_rail_on = 1'b0;
			if ((req == REQ_LOW_RAIL || req == REQ_HIGH_RAIL) && mode != MODE_DISABLED) begin
				check_count = '0;
				check_armed = 1'b1;
				mode = MODE_ACTIVE;
				if (req == REQ_LOW_RAIL)
					low_rail_on = 1'b1;
				else
					high_rail_on = 1'b1;
			end else begin
				check_armed = 1'b0;
				mode = MODE_ENABLED;
			end
		endfunction

		function void predict_pins(op_t op, logic signed [SAMPLE_W-1:0] val);
			pin_state_t r;
			logic list_chg, state_chg, window_fail;
			list_chg = 1'b0;
			state_chg = 1'b0;
			window_fail = 1'b0;
			case (op)
			OP_TARGET: target_level = val;
			OP_USB: begin
				if (val < usb_low_limit)
					power_pin = 1'b1;
				if (val > usb_high_limit)
					power_pin = 1'b0;
			end
			OP_DRIVE: begin
				request_drive(val);
				state_chg = 1'b1;
			end
			default: begin
				if (check_armed && check_count < check_period)
					check_count = check_count + 1'b1;
			end
			endcase

			// window check once the settle period has run out
			if (mode == MODE_ACTIVE && check_armed && check_count >= check_period) begin
				if (high_rail_on && target_level < five_volt_min)
					window_fail = 1'b1;
				else if (low_rail_on &&
				    (target_level < three_volt_min || target_level > three_volt_max))
					window_fail = 1'b1;
				if (window_fail) begin
					request_drive(REQ_OFF);
					state_chg = 1'b1;
				end
			end

			if (mode == MODE_DISABLED && target_level < enable_below && !power_pin) begin
				mode = MODE_ENABLED;
				list_chg = 1'b1;
			end
			if ((mode == MODE_ENABLED && target_level > disable_above) ||
			    (mode != MODE_DISABLED && power_pin)) begin
				low_rail_on = 1'b0;
				high_rail_on = 1'b0;
				mode = MODE_DISABLED;
				list_chg = 1'b1;
			end

			r.low_rail = low_rail_on;
			r.high_rail = high_rail_on;
			r.power_pin = power_pin;
			r.mode = mode;
			r.list_chg = list_chg;
			r.state_chg = state_chg;
			pin_states_q.push_back(r);
		endfunction

		function string pins_text(pin_state_t r);
			return $sformatf("low=%0b high=%0b pin=%0b mode=%0d list=%0b state=%0b",
			    r.low_rail, r.high_rail, r.power_pin, r.mode, r.list_chg, r.state_chg);
		endfunction

		function void flag_mismatch(string what);
			mismatches++;
			if (mismatches <= SHOW_LIMIT)
				$display("%0t: %s", $realtime, what);
		endfunction

		function void check_pins(pin_state_t got);
			pin_state_t want;
			if (pin_states_q.size() == 0) begin
				flag_mismatch({"unexpected result beat: ", pins_text(got)});
			end else begin
				want = pin_states_q.pop_front();
				if (got !== want)
					flag_mismatch({"result mismatch: expected ", pins_text(want),
					    " actual ", pins_text(got)});
			end
		endfunction

		function int pending();
			return pin_states_q.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] opcode = OP_TICK;
	logic signed [SAMPLE_W-1:0] value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic drive_low_rail;
	logic drive_high_rail;
	logic switched_power_pin;
	logic [1:0] drive_mode;
	logic list_changed;
	logic state_changed;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	supervisor_scoreboard sb;
	int hold_off = 0;
	bit steady = 1'b0;
	int reg_plan[8];
	int idle_cycles = 0;

	io_supply_supervisor_top DUT (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic int rand_between(int lo, int hi);
		int offs;
		offs = $urandom_range(0, hi - lo);
		return lo + offs;
	endfunction

	function automatic int unsigned idle_len();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [SAMPLE_W-1:0] near_level(int centre);
		int lvl;
		lvl = centre + rand_between(-4, 4);
		if (lvl > 2047)
			lvl = 2047;
		if (lvl < -2048)
			lvl = -2048;
		return lvl[SAMPLE_W-1:0];
	endfunction

	function automatic logic [SAMPLE_W-1:0] request_code();
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return REQ_LOW_RAIL;
		if (r < 8)
			return REQ_HIGH_RAIL;
		if (r == 8)
			return REQ_OFF;
		return SAMPLE_W'($urandom);
	endfunction

	// steer toward sequences that reach driving and the window checks
	task automatic pick_item(output op_t op, output logic [SAMPLE_W-1:0] val);
		int unsigned r;
		r = $urandom_range(0, 99);
		op = OP_TICK;
		val = SAMPLE_W'($urandom);
		if (r < 15) begin
			op = op_t'($urandom_range(0, 3));
		end else begin
			case (sb.mode)
			MODE_DISABLED: begin
				if (sb.power_pin && r < 70) begin
					op = OP_USB;
					val = near_level(sb.usb_high_limit + 3);
				end else if (r < 85) begin
					op = OP_TARGET;
					val = near_level(sb.enable_below - 2);
				end else begin
					op = OP_DRIVE;
					val = request_code();
				end
			end
			MODE_ENABLED: begin
				if (r < 65) begin
					op = OP_DRIVE;
					val = request_code();
				end else if (r < 85) begin
					op = OP_TARGET;
					val = near_level(sb.disable_above);
				end else begin
					op = OP_USB;
					val = near_level(sb.usb_low_limit);
				end
			end
			default: begin
				if (sb.check_count < sb.check_period && r < 75) begin
					op = OP_TICK;
				end else if (r < 85) begin
					op = OP_TARGET;
					if (sb.high_rail_on)
						val = near_level(sb.five_volt_min);
					else if ($urandom_range(0, 1))
						val = near_level(sb.three_volt_min);
					else
						val = near_level(sb.three_volt_max);
				end else if (r < 93) begin
					op = OP_DRIVE;
					val = request_code();
				end else begin
					op = OP_USB;
					val = near_level(sb.usb_low_limit);
				end
			end
			endcase
		end
	endtask

	task automatic send_beat(op_t op, logic [SAMPLE_W-1:0] val);
		int unsigned gap;
		gap = (steady || $urandom_range(0, 99) < 55) ? 0 : idle_len();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		value <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.predict_pins(op, val);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(cfg_idx_t idx, int val);
		logic [CFG_DATA_W-1:0] data;
		data = val[CFG_DATA_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		sb.write_reg(idx, data);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic make_random_plan(int period);
		int eb, ul, tm;
		eb = rand_between(-300, 300);
		ul = rand_between(-1000, 1000);
		tm = rand_between(-2048, 1500);
		reg_plan = '{eb, eb + rand_between(0, 200), ul, ul + rand_between(0, 300),
		    rand_between(-2048, 2047), tm, tm + rand_between(0, 500), period};
	endtask

	task automatic run_random(int count, bit pressed);
		op_t op;
		logic [SAMPLE_W-1:0] val;
		steady = pressed;
		for (int i = 0; i < count; i++) begin
			if (!pressed && i % 40 == 0)
				steady = ($urandom_range(0, 3) == 0);
			pick_item(op, val);
			send_beat(op, val);
		end
		steady = 1'b0;
	endtask

	// receive side: random stall runs, plus a long hold-off on request
	initial begin
		int run_left;
		bit stalling;
		pin_state_t got;
		run_left = 0;
		stalling = 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.low_rail = drive_low_rail;
				got.high_rail = drive_high_rail;
				got.power_pin = switched_power_pin;
				got.mode = drive_mode;
				got.list_chg = list_changed;
				got.state_chg = state_changed;
				sb.check_pins(got);
			end
			if (hold_off > 0) begin
				hold_off--;
				out_stall <= 1'b1;
			end else begin
				if (run_left == 0) begin
					stalling = ($urandom_range(0, 99) < 35);
					run_left = stalling ? idle_len() : $urandom_range(1, 40);
				end
				run_left--;
				out_stall <= stalling;
			end
		end
	end

	initial begin
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("io_supply_supervisor_top regression: fail");
		$finish;
	end

	initial begin
		sb = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// register defaults: enable and disable paths, every request kind
		send_beat(OP_TICK, 12'h000);
		send_beat(OP_DRIVE, REQ_LOW_RAIL);
		send_beat(OP_USB, 12'h7FF);
		send_beat(OP_TARGET, 12'h800);
		send_beat(OP_TARGET, 12'h7FF);
		send_beat(OP_TARGET, 12'h000);
		send_beat(OP_USB, 12'h800);
		send_beat(OP_USB, 12'h7FF);
		send_beat(OP_DRIVE, REQ_HIGH_RAIL);
		send_beat(OP_TICK, 12'hFFF);
		send_beat(OP_DRIVE, REQ_UNUSED);
		send_beat(OP_DRIVE, 12'hFFF);
		send_beat(OP_DRIVE, REQ_LOW_RAIL);
		send_beat(OP_TARGET, 12'h7FF);
		send_beat(OP_DRIVE, REQ_OFF);
		wait_drained();

		// zero settle period: checks fire on the drive beat itself
		write_reg(REG_CHECK_PERIOD, 0);
		send_beat(OP_TARGET, 12'h000);
		send_beat(OP_DRIVE, REQ_LOW_RAIL);
		send_beat(OP_DRIVE, REQ_HIGH_RAIL);
		send_beat(OP_USB, 12'd1400);
		send_beat(OP_USB, 12'd1000);
		send_beat(OP_USB, 12'd1500);
		send_beat(OP_TICK, 12'h555);
		send_beat(OP_TARGET, 12'h7FF);

		for (int p = 0; p < 6; p++) begin
			wait_drained();
			case (p)
			0: reg_plan = '{111, 185, 1332, 1480, 1630, 1110, 1332, 4};
			1: make_random_plan(rand_between(1, 12));
			2: reg_plan = '{2047, 2047, -2048, -2048, -2048, -2048, 2047, 0};
			3: reg_plan = '{2047, -2048, 2047, -2048, 2047, 2047, -2048, 1};
			4: make_random_plan(65535);
			default: make_random_plan(rand_between(0, 3));
			endcase
			for (int i = 0; i < 8; i++)
				write_reg(cfg_idx_t'(i), reg_plan[i]);
			if (p == 0) begin
				hold_off = 300;
				run_random(40, 1'b1);
				wait_drained();
				run_random(98, 1'b0);
			end else begin
				run_random(138, 1'b0);
			end
		end

		wait_drained();
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("io_supply_supervisor_top regression: pass");
		else
			$display("io_supply_supervisor_top regression: fail");
		$finish;
	end

endmodule
